// ===== hw/rtl/eqor_pkg.sv =====
package eqor_pkg;

    typedef enum logic [2:0] {
        CMD_PUBLISH      = 3'd0,
        CMD_REPORT_LOSS  = 3'd1,
        CMD_DELIVER      = 3'd2,
        CMD_ACK_RESCAN   = 3'd3,
        CMD_CLOSE        = 3'd4,
        CMD_BACKEND_DONE = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_BUFFERS = 2'd1,
        STAT_SHUT_DOWN  = 2'd2,
        STAT_ALREADY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        LIFE_OPEN    = 2'd0,
        LIFE_CLOSING = 2'd1,
        LIFE_CLOSED  = 2'd2
    } lifecycle_t;

    localparam logic [1:0] CFG_QUEUE_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_PATH_LIMIT     = 2'd1;
    localparam logic [1:0] CFG_MAX_KIND       = 2'd2;

    localparam logic [4:0]  CAPACITY_RESET   = 5'd16;
    localparam logic [15:0] PATH_LIMIT_RESET = 16'd256;
    localparam logic [3:0]  MAX_KIND_RESET   = 4'd7;

    localparam logic [2:0] ENTRY_UNKNOWN = 3'd0;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  kind;
        logic [2:0]  etype;
        logic [31:0] path_ref;
        logic [15:0] path_len;
        logic [31:0] old_path_ref;
        logic [15:0] old_path_len;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        event_valid;
        logic        is_rescan;
        logic [3:0]  out_kind;
        logic [2:0]  out_etype;
        logic [31:0] out_path_ref;
        logic [31:0] out_old_path_ref;
        logic [4:0]  queued;
        logic        awaiting_flag;
        logic [1:0]  lifecycle;
        logic [31:0] suppressed_count;
        logic [31:0] rescan_count;
    } res_beat_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ===== hw/rtl/eqor_cmd_if.sv =====
interface eqor_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [3:0]  kind;
    logic [2:0]  etype;
    logic [31:0] path_ref;
    logic [15:0] path_len;
    logic [31:0] old_path_ref;
    logic [15:0] old_path_len;

    modport source (
        output valid, cmd, kind, etype, path_ref, path_len, old_path_ref, old_path_len,
        input  ready
    );

    modport sink (
        input  valid, cmd, kind, etype, path_ref, path_len, old_path_ref, old_path_len,
        output ready
    );
endinterface

// ===== hw/rtl/eqor_res_if.sv =====
interface eqor_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        event_valid;
    logic        is_rescan;
    logic [3:0]  out_kind;
    logic [2:0]  out_etype;
    logic [31:0] out_path_ref;
    logic [31:0] out_old_path_ref;
    logic [4:0]  queued;
    logic        awaiting_flag;
    logic [1:0]  lifecycle;
    logic [31:0] suppressed_count;
    logic [31:0] rescan_count;

    modport source (
        output valid, status, event_valid, is_rescan, out_kind, out_etype,
               out_path_ref, out_old_path_ref, queued, awaiting_flag, lifecycle,
               suppressed_count, rescan_count,
        input  ready
    );

    modport sink (
        input  valid, status, event_valid, is_rescan, out_kind, out_etype,
               out_path_ref, out_old_path_ref, queued, awaiting_flag, lifecycle,
               suppressed_count, rescan_count,
        output ready
    );
endinterface

// ===== hw/rtl/eqor_ring.sv =====
module eqor_ring #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 71,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // forward a same-cycle write so the head entry is never stale
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/event_queue_overflow_rescan_top.sv =====
// A command is held in the input register, then its result in the result register (2 register stages).
// One command per cycle unless a held result stalls the input; the result register and ring read port set this.
// The head entry of the ring is prefetched into a registered read port every cycle.
// Reset (rst_n low, asynchronous) clears pointers, counters, flags and the configuration
// registers to their defaults; ring contents are not cleared and need no clearing pass.
module event_queue_overflow_rescan_top
    import eqor_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    eqor_cmd_if.sink    req,
    eqor_res_if.source  rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 2 * HANDLE_BITS + 7;

    // configuration
    logic [4:0]  capacity_reg;
    logic [15:0] path_limit_reg;
    logic [3:0]  max_kind_reg;

    // pipeline
    logic      in_valid_reg;
    cmd_beat_t in_reg;
    logic      res_valid_reg;
    res_beat_t res_reg;
    res_beat_t res_next;
    logic      fire;

    // state
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              awaiting_reg, awaiting_next;
    logic              pending_reg, pending_next;
    logic              handed_reg, handed_next;
    logic [31:0]       lost_reg, lost_next;
    logic [31:0]       lost_at_reg, lost_at_next;
    logic [31:0]       rescan_reg, rescan_next;
    logic              close_reg, close_next;
    logic              backend_reg, backend_next;

    // ring port
    logic               ring_we;
    logic [ENTRY_W-1:0] ring_wdata;
    logic [ENTRY_W-1:0] ring_rdata;

    logic [FILL_W-1:0]      cap_eff;
    logic [HANDLE_BITS-1:0] pref_m, oref_m;
    logic [HANDLE_BITS-1:0] pref_e, oref_e;
    logic [15:0]            plen_e, olen_e;

    function automatic logic [IDX_W-1:0] wrap_inc(
        input logic [IDX_W-1:0]  idx,
        input logic [FILL_W-1:0] cap
    );
        logic [31:0] n;
        n = 32'(idx) + 32'd1;
        wrap_inc = (n >= 32'(cap)) ? '0 : IDX_W'(n);
    endfunction

    always_comb
    begin
        if (capacity_reg == 5'd0)
        begin
            cap_eff = FILL_W'(1);
        end
        else if (32'(capacity_reg) > 32'(DEPTH))
        begin
            cap_eff = FILL_W'(DEPTH);
        end
        else
        begin
            cap_eff = FILL_W'(capacity_reg);
        end
    end

    // absent path: zero handle or zero length
    always_comb
    begin
        pref_m = in_reg.path_ref[HANDLE_BITS-1:0];
        oref_m = in_reg.old_path_ref[HANDLE_BITS-1:0];
        if ((pref_m == '0) || (in_reg.path_len == 16'd0))
        begin
            pref_e = '0;
            plen_e = 16'd0;
        end
        else
        begin
            pref_e = pref_m;
            plen_e = in_reg.path_len;
        end
        if ((oref_m == '0) || (in_reg.old_path_len == 16'd0))
        begin
            oref_e = '0;
            olen_e = 16'd0;
        end
        else
        begin
            oref_e = oref_m;
            olen_e = in_reg.old_path_len;
        end
    end

    assign fire      = in_valid_reg && (!res_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || fire;

    assign ring_wdata = {oref_e, pref_e, in_reg.etype, in_reg.kind};

    always_comb
    begin
        logic loss;
        logic latch;

        loss          = 1'b0;
        latch         = 1'b0;
        ring_we       = 1'b0;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        awaiting_next = awaiting_reg;
        pending_next  = pending_reg;
        handed_next   = handed_reg;
        lost_next     = lost_reg;
        lost_at_next  = lost_at_reg;
        rescan_next   = rescan_reg;
        close_next    = close_reg;
        backend_next  = backend_reg;
        res_next      = '0;
        res_next.status = STAT_OK;

        if (fire)
        begin
            case (in_reg.cmd)
                CMD_PUBLISH:
                begin
                    if ((in_reg.kind > max_kind_reg) || (plen_e >= path_limit_reg)
                        || (olen_e >= path_limit_reg))
                    begin
                        loss  = 1'b1;
                        latch = 1'b1;
                        res_next.status = STAT_NO_BUFFERS;
                    end
                    else if (close_reg)
                    begin
                        loss = 1'b1;
                        res_next.status = STAT_SHUT_DOWN;
                    end
                    else if (awaiting_reg || (fill_reg >= cap_eff))
                    begin
                        loss  = 1'b1;
                        latch = 1'b1;
                        res_next.status = STAT_NO_BUFFERS;
                    end
                    else
                    begin
                        ring_we   = 1'b1;
                        tail_next = wrap_inc(tail_reg, cap_eff);
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                CMD_REPORT_LOSS:
                begin
                    loss  = 1'b1;
                    latch = 1'b1;
                end
                CMD_DELIVER:
                begin
                    if (fill_reg != '0)
                    begin
                        res_next.event_valid      = 1'b1;
                        res_next.out_kind         = ring_rdata[3:0];
                        res_next.out_etype        = ring_rdata[6:4];
                        res_next.out_path_ref     = 32'(ring_rdata[7 +: HANDLE_BITS]);
                        res_next.out_old_path_ref =
                            32'(ring_rdata[7 + HANDLE_BITS +: HANDLE_BITS]);
                        head_next = wrap_inc(head_reg, cap_eff);
                        fill_next = fill_reg - FILL_W'(1);
                    end
                    else if (pending_reg)
                    begin
                        pending_next         = 1'b0;
                        handed_next          = 1'b1;
                        lost_at_next         = lost_reg;
                        res_next.event_valid = 1'b1;
                        res_next.is_rescan   = 1'b1;
                        res_next.out_etype   = ENTRY_UNKNOWN;
                    end
                end
                CMD_ACK_RESCAN:
                begin
                    if (!awaiting_reg || !handed_reg)
                    begin
                        res_next.status = STAT_ALREADY;
                    end
                    else if (lost_reg != lost_at_reg)
                    begin
                        // losses since hand-out: re-arm the marker
                        pending_next = 1'b1;
                        handed_next  = 1'b0;
                        rescan_next  = sat_inc(rescan_reg);
                    end
                    else
                    begin
                        awaiting_next = 1'b0;
                        handed_next   = 1'b0;
                    end
                end
                CMD_CLOSE:
                begin
                    if (close_reg)
                    begin
                        res_next.status = STAT_ALREADY;
                    end
                    else
                    begin
                        close_next = 1'b1;
                    end
                end
                CMD_BACKEND_DONE:
                begin
                    backend_next = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (loss)
            begin
                lost_next = sat_inc(lost_reg);
            end
            if (latch && !awaiting_reg)
            begin
                awaiting_next = 1'b1;
                pending_next  = 1'b1;
                handed_next   = 1'b0;
                rescan_next   = sat_inc(rescan_reg);
            end
        end

        res_next.queued        = 5'(32'(fill_next) + 32'(pending_next));
        res_next.awaiting_flag = awaiting_next;
        if (!close_next)
        begin
            res_next.lifecycle = LIFE_OPEN;
        end
        else if (backend_next)
        begin
            res_next.lifecycle = LIFE_CLOSED;
        end
        else
        begin
            res_next.lifecycle = LIFE_CLOSING;
        end
        res_next.suppressed_count = lost_next;
        res_next.rescan_count     = rescan_next;
    end

    eqor_ring #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_W),
        .IDX_W (IDX_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (tail_reg),
        .wr_data (ring_wdata),
        .rd_addr (head_next),
        .rd_data (ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAPACITY_RESET;
            path_limit_reg <= PATH_LIMIT_RESET;
            max_kind_reg   <= MAX_KIND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUEUE_CAPACITY: capacity_reg   <= cfg_wdata[4:0];
                CFG_PATH_LIMIT:     path_limit_reg <= cfg_wdata;
                CFG_MAX_KIND:       max_kind_reg   <= cfg_wdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            awaiting_reg  <= 1'b0;
            pending_reg   <= 1'b0;
            handed_reg    <= 1'b0;
            lost_reg      <= '0;
            lost_at_reg   <= '0;
            rescan_reg    <= '0;
            close_reg     <= 1'b0;
            backend_reg   <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            awaiting_reg <= awaiting_next;
            pending_reg  <= pending_next;
            handed_reg   <= handed_next;
            lost_reg     <= lost_next;
            lost_at_reg  <= lost_at_next;
            rescan_reg   <= rescan_next;
            close_reg    <= close_next;
            backend_reg  <= backend_next;
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_reg.cmd          <= req.cmd;
            in_reg.kind         <= req.kind;
            in_reg.etype        <= req.etype;
            in_reg.path_ref     <= req.path_ref;
            in_reg.path_len     <= req.path_len;
            in_reg.old_path_ref <= req.old_path_ref;
            in_reg.old_path_len <= req.old_path_len;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid            = res_valid_reg;
    assign rsp.status           = res_reg.status;
    assign rsp.event_valid      = res_reg.event_valid;
    assign rsp.is_rescan        = res_reg.is_rescan;
    assign rsp.out_kind         = res_reg.out_kind;
    assign rsp.out_etype        = res_reg.out_etype;
    assign rsp.out_path_ref     = res_reg.out_path_ref;
    assign rsp.out_old_path_ref = res_reg.out_old_path_ref;
    assign rsp.queued           = res_reg.queued;
    assign rsp.awaiting_flag    = res_reg.awaiting_flag;
    assign rsp.lifecycle        = res_reg.lifecycle;
    assign rsp.suppressed_count = res_reg.suppressed_count;
    assign rsp.rescan_count     = res_reg.rescan_count;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(DEPTH))
        else $error("fill count beyond ring depth");

    a_pending_awaits: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> awaiting_reg)
        else $error("rescan marker pending without awaiting state");

    a_handed_excl: assert property (@(posedge clk) disable iff (!rst_n)
        handed_reg |-> (awaiting_reg && !pending_reg))
        else $error("rescan handed out while still pending or not awaited");

    a_rescan_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(rescan_reg) |-> (rescan_reg > $past(rescan_reg)))
        else $error("rescan counter moved backward");

    a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(head_reg) && $stable(tail_reg) && $stable(fill_reg)))
        else $error("ring pointers moved without a command");
`endif

endmodule

// ===== tb/sv/event_queue_overflow_rescan_top_tb.sv =====
`timescale 1ns / 100ps

module event_queue_overflow_rescan_top_tb;
    import eqor_pkg::*;

    localparam int RING_DEPTH = 16;
    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TAIL_CYCLES = 4;
    localparam int REPORT_LIMIT = 10;
    localparam int STALL_CYCLES = 300;
    localparam int unsigned TIMEOUT_NS = 7_200_000;

    // command codes with no operation behind them
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    eqor_cmd_if req ();
    eqor_res_if rsp ();

    event_queue_overflow_rescan_top #(
        .DEPTH       (RING_DEPTH),
        .HANDLE_BITS (32)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // ring and protocol state of the predictor
    logic [31:0] ring_path     [RING_DEPTH];
    logic [31:0] ring_old_path [RING_DEPTH];
    logic [3:0]  ring_kind     [RING_DEPTH];
    logic [2:0]  ring_etype    [RING_DEPTH];
    int unsigned head_ptr;
    int unsigned tail_ptr;
    int unsigned ring_fill;
    bit          awaiting;
    bit          rescan_armed;
    bit          rescan_out;
    bit          close_req;
    bit          backend_gone;
    logic [31:0] lost_cnt;
    logic [31:0] lost_snap;
    logic [31:0] rescan_cnt;
    logic [4:0]  capacity_reg;
    logic [15:0] path_limit_reg;
    logic [3:0]  max_kind_reg;

    res_beat_t answer_q [$];
    int        errors = 0;
    int        src_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        stall_len = 0;
    bit        stall_tog = 1'b0;

    task automatic reset_model();
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_path[i] = '0;
            ring_old_path[i] = '0;
            ring_kind[i] = '0;
            ring_etype[i] = '0;
        end
        head_ptr = 0;
        tail_ptr = 0;
        ring_fill = 0;
        awaiting = 1'b0;
        rescan_armed = 1'b0;
        rescan_out = 1'b0;
        close_req = 1'b0;
        backend_gone = 1'b0;
        lost_cnt = '0;
        lost_snap = '0;
        rescan_cnt = '0;
        capacity_reg = CAPACITY_RESET;
        path_limit_reg = PATH_LIMIT_RESET;
        max_kind_reg = MAX_KIND_RESET;
    endtask

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int unsigned slots_in_use();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > RING_DEPTH)
            return RING_DEPTH;
        return capacity_reg;
    endfunction

    function automatic int unsigned advance_ptr(input int unsigned p);
        return (p + 1 >= slots_in_use()) ? 0 : p + 1;
    endfunction

    task automatic count_loss_and_arm();
        lost_cnt = bump(lost_cnt);
        if (!awaiting)
        begin
            awaiting = 1'b1;
            rescan_armed = 1'b1;
            rescan_out = 1'b0;
            rescan_cnt = bump(rescan_cnt);
        end
    endtask

    task automatic predict_command(input cmd_beat_t b, output res_beat_t r);
        logic [31:0] pref;
        logic [31:0] oref;
        int unsigned plen;
        int unsigned olen;
        int unsigned slot;
        r = '0;
        pref = b.path_ref;
        plen = b.path_len;
        oref = b.old_path_ref;
        olen = b.old_path_len;
        // an absent path has no length
        if (pref == 0 || plen == 0)
        begin
            pref = '0;
            plen = 0;
        end
        if (oref == 0 || olen == 0)
        begin
            oref = '0;
            olen = 0;
        end
        case (b.cmd)
            CMD_PUBLISH:
            begin
                if (b.kind > max_kind_reg || plen >= path_limit_reg || olen >= path_limit_reg)
                begin
                    count_loss_and_arm();
                    r.status = STAT_NO_BUFFERS;
                end
                else if (close_req)
                begin
                    lost_cnt = bump(lost_cnt);
                    r.status = STAT_SHUT_DOWN;
                end
                else if (awaiting || ring_fill >= slots_in_use())
                begin
                    count_loss_and_arm();
                    r.status = STAT_NO_BUFFERS;
                end
                else
                begin
                    slot = tail_ptr % RING_DEPTH;
                    ring_path[slot] = pref;
                    ring_old_path[slot] = oref;
                    ring_kind[slot] = b.kind;
                    ring_etype[slot] = b.etype;
                    tail_ptr = advance_ptr(slot);
                    ring_fill++;
                end
            end
            CMD_REPORT_LOSS:
                count_loss_and_arm();
            CMD_DELIVER:
            begin
                if (ring_fill != 0)
                begin
                    slot = head_ptr % RING_DEPTH;
                    r.event_valid = 1'b1;
                    r.out_kind = ring_kind[slot];
                    r.out_etype = ring_etype[slot];
                    r.out_path_ref = ring_path[slot];
                    r.out_old_path_ref = ring_old_path[slot];
                    head_ptr = advance_ptr(slot);
                    ring_fill--;
                end
                else if (rescan_armed)
                begin
                    rescan_armed = 1'b0;
                    rescan_out = 1'b1;
                    lost_snap = lost_cnt;
                    r.event_valid = 1'b1;
                    r.is_rescan = 1'b1;
                    r.out_etype = ENTRY_UNKNOWN;
                end
            end
            CMD_ACK_RESCAN:
            begin
                if (!awaiting || !rescan_out)
                    r.status = STAT_ALREADY;
                else if (lost_cnt != lost_snap)
                begin
                    // losses since hand-out: re-arm the marker
                    rescan_armed = 1'b1;
                    rescan_out = 1'b0;
                    rescan_cnt = bump(rescan_cnt);
                end
                else
                begin
                    awaiting = 1'b0;
                    rescan_out = 1'b0;
                end
            end
            CMD_CLOSE:
            begin
                if (close_req)
                    r.status = STAT_ALREADY;
                else
                    close_req = 1'b1;
            end
            CMD_BACKEND_DONE:
                backend_gone = 1'b1;
            default:
                ;
        endcase
        r.queued = 5'(ring_fill + (rescan_armed ? 1 : 0));
        r.awaiting_flag = awaiting;
        r.lifecycle = !close_req ? LIFE_OPEN : (backend_gone ? LIFE_CLOSED : LIFE_CLOSING);
        r.suppressed_count = lost_cnt;
        r.rescan_count = rescan_cnt;
    endtask

    function automatic cmd_beat_t make_beat(input logic [2:0] cmd, input logic [3:0] kind,
                                            input logic [2:0] etype,
                                            input logic [31:0] pref, input logic [15:0] plen,
                                            input logic [31:0] oref, input logic [15:0] olen);
        cmd_beat_t b;
        b.cmd = cmd;
        b.kind = kind;
        b.etype = etype;
        b.path_ref = pref;
        b.path_len = plen;
        b.old_path_ref = oref;
        b.old_path_len = olen;
        return b;
    endfunction

    function automatic logic [15:0] pick_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 18)
            return 16'($urandom_range(path_limit_reg, 16'hFFFF));
        return 16'($urandom_range(1, path_limit_reg - 1));
    endfunction

    // mostly well-formed traffic, shaped by where the protocol currently stands
    function automatic cmd_beat_t random_beat(input bit all_cmds);
        cmd_beat_t   b;
        int unsigned roll;
        b.cmd = CMD_DELIVER;
        b.kind = 4'($urandom_range(0, 15));
        b.etype = 3'($urandom_range(0, 7));
        b.path_ref = $urandom;
        b.path_len = 16'($urandom);
        b.old_path_ref = $urandom;
        b.old_path_len = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (awaiting && rescan_out && roll < 35)
            b.cmd = CMD_ACK_RESCAN;
        else if (roll < 50)
        begin
            b.cmd = CMD_PUBLISH;
            if ($urandom_range(0, 99) < 88)
                b.kind = 4'($urandom_range(0, max_kind_reg));
            if ($urandom_range(0, 99) < 8)
                b.path_ref = '0;
            b.path_len = pick_len();
            if ($urandom_range(0, 1) != 0)
            begin
                if ($urandom_range(0, 1) != 0)
                    b.old_path_ref = '0;
                else
                    b.old_path_len = '0;
            end
            else
                b.old_path_len = pick_len();
        end
        else if (roll < 86)
            b.cmd = CMD_DELIVER;
        else if (roll < 90)
            b.cmd = CMD_REPORT_LOSS;
        else if (roll < 95)
            b.cmd = CMD_ACK_RESCAN;
        else if (roll < 98)
        begin
            case ($urandom_range(0, all_cmds ? 3 : 1))
                0: b.cmd = CMD_SPARE_LO;
                1: b.cmd = CMD_SPARE_HI;
                2: b.cmd = CMD_CLOSE;
                default: b.cmd = CMD_BACKEND_DONE;
            endcase
        end
        else
            b.cmd = CMD_PUBLISH;
        return b;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
            flag_error($sformatf("%s expected 0x%0h actual 0x%0h", name, want, got));
    endtask

    task automatic send_cmd(input cmd_beat_t b);
        res_beat_t want;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        req.valid <= 1'b1;
        req.cmd <= b.cmd;
        req.kind <= b.kind;
        req.etype <= b.etype;
        req.path_ref <= b.path_ref;
        req.path_len <= b.path_len;
        req.old_path_ref <= b.old_path_ref;
        req.old_path_len <= b.old_path_len;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_command(b, want);
        answer_q.push_back(want);
    endtask

    task automatic wait_drained();
        int waited;
        req.valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (answer_q.size() != 0 && waited < DRAIN_LIMIT);
        if (answer_q.size() != 0)
        begin
            flag_error($sformatf("%0d results never arrived", answer_q.size()));
            answer_q.delete();
        end
    endtask

    // deliver until the ring holds nothing, so a capacity change never exposes stale slots
    task automatic empty_ring();
        while (ring_fill != 0)
            send_cmd(make_beat(CMD_DELIVER, 4'($urandom), 3'($urandom), $urandom,
                               16'($urandom), $urandom, 16'($urandom)));
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
        if (idx == CFG_QUEUE_CAPACITY)
            empty_ring();
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_QUEUE_CAPACITY: capacity_reg = val[4:0];
            CFG_PATH_LIMIT:     path_limit_reg = val;
            CFG_MAX_KIND:       max_kind_reg = val[3:0];
            default:            ;
        endcase
    endtask

    task automatic set_idling(input int src_pct, input int rx_pct);
        src_idle_pct = src_pct;
        rx_idle_pct <= rx_pct;
    endtask

    task automatic pick_settings();
        logic [15:0] cap;
        logic [15:0] plim;
        logic [15:0] kmax;
        case ($urandom_range(0, 9))
            0: cap = 16'd0;
            1: cap = 16'd1;
            2: cap = 16'd16;
            3: cap = 16'd31;
            default: cap = 16'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 5))
            0: plim = 16'd2;
            1: plim = 16'hFFFF;
            2: plim = 16'd256;
            default: plim = 16'($urandom_range(2, 16'hFFFF));
        endcase
        case ($urandom_range(0, 5))
            0: kmax = 16'd0;
            1: kmax = 16'd15;
            default: kmax = 16'($urandom_range(0, 15));
        endcase
        write_cfg(CFG_QUEUE_CAPACITY, cap);
        write_cfg(CFG_PATH_LIMIT, plim);
        write_cfg(CFG_MAX_KIND, kmax);
    endtask

    task automatic test_publish_paths();
        send_cmd(make_beat(CMD_PUBLISH, 4'd0, 3'd0, 32'd1, 16'd1, 32'd0, 16'd0));
        send_cmd(make_beat(CMD_PUBLISH, 4'd7, 3'd7, 32'hFFFF_FFFF, 16'd255,
                           32'hFFFF_FFFF, 16'd255));
        // handle 0 means absent even with a length
        send_cmd(make_beat(CMD_PUBLISH, 4'd3, 3'd5, 32'd0, 16'd100, 32'h8000_0000, 16'd1));
        // zero lengths drop the handle; an absent old path is never too long
        send_cmd(make_beat(CMD_PUBLISH, 4'd1, 3'd2, 32'h1234_5678, 16'd0, 32'd0, 16'hFFFF));
        repeat (5)
            send_cmd(make_beat(CMD_DELIVER, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_SPARE_LO, 4'hF, 3'd7, 32'hFFFF_FFFF, 16'hFFFF,
                           32'hFFFF_FFFF, 16'hFFFF));
        send_cmd(make_beat(CMD_SPARE_HI, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_ACK_RESCAN, '0, '0, '0, '0, '0, '0));
    endtask

    task automatic test_loss_and_rescan();
        send_cmd(make_beat(CMD_PUBLISH, 4'd8, 3'd1, 32'd9, 16'd3, 32'd0, 16'd0));
        send_cmd(make_beat(CMD_PUBLISH, 4'd2, 3'd1, 32'd9, 16'd256, 32'd0, 16'd0));
        send_cmd(make_beat(CMD_PUBLISH, 4'd2, 3'd1, 32'd9, 16'd4, 32'd7, 16'd256));
        send_cmd(make_beat(CMD_PUBLISH, 4'd2, 3'd1, 32'd9, 16'd4, 32'd0, 16'd0));
        send_cmd(make_beat(CMD_DELIVER, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_REPORT_LOSS, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_ACK_RESCAN, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_DELIVER, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_ACK_RESCAN, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_ACK_RESCAN, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_PUBLISH, 4'd5, 3'd4, 32'd0, 16'd300, 32'd0, 16'd0));
        send_cmd(make_beat(CMD_DELIVER, '0, '0, '0, '0, '0, '0));
    endtask

    task automatic test_full_ring();
        write_cfg(CFG_QUEUE_CAPACITY, 16'd2);
        repeat (3)
            send_cmd(make_beat(CMD_PUBLISH, 4'd6, 3'd3, $urandom, 16'd10, $urandom, 16'd20));
        repeat (3)
            send_cmd(make_beat(CMD_DELIVER, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_ACK_RESCAN, '0, '0, '0, '0, '0, '0));
        write_cfg(CFG_QUEUE_CAPACITY, 16'd16);
    endtask

    task automatic test_random_traffic(input int n_items);
        int left;
        int chunk;
        left = n_items;
        while (left > 0)
        begin
            pick_settings();
            chunk = $urandom_range(60, 140);
            if (chunk > left)
                chunk = left;
            repeat (chunk)
                send_cmd(random_beat(1'b0));
            left -= chunk;
        end
    endtask

    // hold the result side off while commands keep coming, so the input stalls
    task automatic test_backpressure();
        write_cfg(CFG_QUEUE_CAPACITY, 16'd16);
        write_cfg(CFG_PATH_LIMIT, 16'hFFFF);
        write_cfg(CFG_MAX_KIND, 16'd15);
        stall_len <= STALL_CYCLES;
        stall_tog <= ~stall_tog;
        repeat (60)
            send_cmd(random_beat(1'b0));
    endtask

    task automatic test_shutdown();
        write_cfg(CFG_MAX_KIND, 16'd7);
        write_cfg(CFG_PATH_LIMIT, 16'd256);
        send_cmd(make_beat(CMD_PUBLISH, 4'd1, 3'd1, 32'd3, 16'd3, 32'd0, 16'd0));
        send_cmd(make_beat(CMD_CLOSE, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_PUBLISH, 4'd1, 3'd1, 32'd3, 16'd3, 32'd0, 16'd0));
        // a bad kind still arms a rescan while closing, unless one is already awaited
        send_cmd(make_beat(CMD_PUBLISH, 4'd9, 3'd1, 32'd3, 16'd3, 32'd0, 16'd0));
        send_cmd(make_beat(CMD_CLOSE, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_BACKEND_DONE, '0, '0, '0, '0, '0, '0));
        send_cmd(make_beat(CMD_DELIVER, '0, '0, '0, '0, '0, '0));
        repeat (100)
            send_cmd(random_beat(1'b1));
    endtask

    initial
    begin : rx_ready
        int stall_left;
        bit stall_seen;
        rsp.ready = 1'b0;
        stall_left = 0;
        stall_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_tog != stall_seen)
            begin
                stall_seen = stall_tog;
                stall_left = stall_len;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_answers
        res_beat_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answer_q.size() == 0)
                flag_error("result beat with nothing expected");
            else
            begin
                want = answer_q.pop_front();
                compare_field("status", want.status, rsp.status);
                compare_field("event_valid", want.event_valid, rsp.event_valid);
                compare_field("is_rescan", want.is_rescan, rsp.is_rescan);
                compare_field("out_kind", want.out_kind, rsp.out_kind);
                compare_field("out_etype", want.out_etype, rsp.out_etype);
                compare_field("out_path_ref", want.out_path_ref, rsp.out_path_ref);
                compare_field("out_old_path_ref", want.out_old_path_ref, rsp.out_old_path_ref);
                compare_field("queued", want.queued, rsp.queued);
                compare_field("awaiting_flag", want.awaiting_flag, rsp.awaiting_flag);
                compare_field("lifecycle", want.lifecycle, rsp.lifecycle);
                compare_field("suppressed_count", want.suppressed_count, rsp.suppressed_count);
                compare_field("rescan_count", want.rescan_count, rsp.rescan_count);
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("event_queue_overflow_rescan_top_tb: errors");
        $finish;
    end

    initial
    begin : run_tests
        cfg_we = 1'b0;
        cfg_index = CFG_QUEUE_CAPACITY;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.cmd = CMD_DELIVER;
        req.kind = '0;
        req.etype = '0;
        req.path_ref = '0;
        req.path_len = '0;
        req.old_path_ref = '0;
        req.old_path_len = '0;
        reset_model();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_publish_paths();
        test_loss_and_rescan();
        test_full_ring();
        set_idling(16, 62);
        test_random_traffic(430);
        set_idling(62, 16);
        test_random_traffic(430);
        set_idling(0, 0);
        test_backpressure();
        test_random_traffic(350);
        test_shutdown();
        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("event_queue_overflow_rescan_top_tb: clean");
        else
            $display("event_queue_overflow_rescan_top_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/eqor_pkg.sv
hw/rtl/eqor_cmd_if.sv
hw/rtl/eqor_res_if.sv
hw/rtl/eqor_ring.sv
hw/rtl/event_queue_overflow_rescan_top.sv
tb/sv/event_queue_overflow_rescan_top_tb.sv
